// ===== hw/rtl/elbow_angle_velocity_law_defines.svh =====
// Assertion macros shared by the checker files of the elbow angle velocity law.
// Needs a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef ELBOW_ANGLE_VELOCITY_LAW_DEFINES_SVH
`define ELBOW_ANGLE_VELOCITY_LAW_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EAVL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("eavl assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define EAVL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("eavl assertion failed");

`endif

// ===== hw/rtl/eavl_pkg.sv =====
// Package of the elbow angle velocity law: field widths, fixed-point constants,
// register indexes and the arccosine polynomial. Depends on nothing.
package eavl_pkg;

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 88;
  localparam int CFG_DATA_W  = 20;

  localparam int POS_W   = 20;
  localparam int ANGLE_W = 19;
  localparam int LEN_W   = 18;
  localparam int DIST_W  = 19;
  localparam int ERR_W   = 20;
  localparam int VEL_W   = 28;
  localparam int GAIN_W  = 8;

  // Divider geometry: the denominator 2*Lua*Lee fits 37 bits, the quotient is
  // the cosine magnitude in Q.24 and never exceeds 2^24.
  localparam int DEN_W = 37;
  localparam int Q_W   = 25;

  localparam logic [LEN_W-1:0] LEN_MAX = 18'd131072;
  localparam int               PI_Q16  = 205887;
  localparam logic [Q_W-1:0]   ONE_Q24 = 25'd16777216;

  // Horner coefficients of the arccosine polynomial, highest order first, Q.30.
  localparam int P_W = 34;
  localparam logic signed [P_W-1:0] ACOS_COEF [8] = '{
    -34'sd1355590, 34'sd7161955, -34'sd18348235, 34'sd33169905,
    -34'sd53874249, 34'sd95540460, -34'sd230423709, 34'sd1686629690
  };

  typedef enum logic [2:0] {
    CFG_REF_X    = 3'd0,
    CFG_REF_Y    = 3'd1,
    CFG_REF_Z    = 3'd2,
    CFG_UPPER    = 3'd3,
    CFG_FOREARM  = 3'd4,
    CFG_MARKER   = 3'd5,
    CFG_GAIN     = 3'd6,
    CFG_DEADZONE = 3'd7
  } cfg_reg_t;

endpackage

// ===== hw/rtl/eavl_isqrt.sv =====
// Pipelined restoring integer square root, one root bit per register stage.
// Carries a valid bit and a sideband word alongside; no package dependency.
module eavl_isqrt #(
  parameter int IN_W   = 42,
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [IN_W-1:0]     in_rad,
  input  logic [SIDE_W-1:0]   in_side,
  output logic                out_valid,
  output logic [IN_W/2-1:0]   out_root,
  output logic [IN_W/2+2:0]   out_rem,
  output logic [SIDE_W-1:0]   out_side
);

  localparam int ROOT_W = IN_W / 2;
  localparam int REM_W  = ROOT_W + 3;

  logic              vld_r  [ROOT_W];
  logic [IN_W-1:0]   rad_r  [ROOT_W];
  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  logic [SIDE_W-1:0] side_r [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic              v_in;
    logic [IN_W-1:0]   rad_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [SIDE_W-1:0] side_in;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              ge;
    logic [REM_W-1:0]  rem_nxt;
    logic [ROOT_W-1:0] root_nxt;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign rad_in  = in_rad;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = vld_r[k-1];
      assign rad_in  = rad_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign side_in = side_r[k-1];
    end

    always_comb begin
      rem_sh   = {rem_in[REM_W-3:0], rad_in[IN_W-1 -: 2]};
      trial    = {1'b0, root_in, 2'b01};
      ge       = (rem_sh >= trial);
      rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
      root_nxt = {root_in[ROOT_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k]  <= {rad_in[IN_W-3:0], 2'b00};
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        side_r[k] <= side_in;
      end
    end
  end

  assign out_valid = vld_r[ROOT_W-1];
  assign out_root  = root_r[ROOT_W-1];
  assign out_rem   = rem_r[ROOT_W-1];
  assign out_side  = side_r[ROOT_W-1];

endmodule

// ===== hw/rtl/eavl_div.sv =====
// Pipelined restoring divider forming the cosine magnitude |num| * 2^24 / den.
// One quotient bit per stage; widths come from eavl_pkg.
module eavl_div #(
  parameter int SIDE_W = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic [eavl_pkg::DEN_W-1:0] den,
  input  logic                       in_valid,
  input  logic [eavl_pkg::DEN_W-1:0] in_mag,
  input  logic [SIDE_W-1:0]          in_side,
  output logic                       out_valid,
  output logic [eavl_pkg::Q_W-1:0]   out_quot,
  output logic [SIDE_W-1:0]          out_side
);

  localparam int DW = eavl_pkg::DEN_W;
  localparam int QW = eavl_pkg::Q_W;

  logic              vld_r  [QW];
  logic [DW-1:0]     rem_r  [QW];
  logic [QW-1:0]     quot_r [QW];
  logic [SIDE_W-1:0] side_r [QW];

  // The denominator comes from configuration, which users must keep still while
  // items are in flight (unenforced), so all stages share it, not carried along.
  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic              v_in;
    logic [DW:0]       rem_sh;
    logic [QW-1:0]     quot_in;
    logic [SIDE_W-1:0] side_in;
    logic              ge;
    logic [DW:0]       rem_nxt;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_sh  = {1'b0, in_mag};
      assign quot_in = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = vld_r[k-1];
      assign rem_sh  = {rem_r[k-1], 1'b0};
      assign quot_in = quot_r[k-1];
      assign side_in = side_r[k-1];
    end

    always_comb begin
      ge      = (rem_sh >= {1'b0, den});
      rem_nxt = ge ? (rem_sh - {1'b0, den}) : rem_sh;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt[DW-1:0];
        quot_r[k] <= {quot_in[QW-2:0], ge};
        side_r[k] <= side_in;
      end
    end
  end

  assign out_valid = vld_r[QW-1];
  assign out_quot  = quot_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule

// ===== hw/rtl/eavl_acos.sv =====
// Pipelined arccosine: Horner polynomial, square root of (1 - a), product and
// rounding to Q.16. Uses eavl_pkg constants and instantiates eavl_isqrt.
module eavl_acos #(
  parameter int SIDE_W = 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [eavl_pkg::Q_W-1:0] in_a,
  input  logic [SIDE_W-1:0]        in_side,
  output logic                     out_valid,
  output logic [19:0]              out_angle,
  output logic [SIDE_W-1:0]        out_side
);

  localparam int QW    = eavl_pkg::Q_W;
  localparam int PW    = eavl_pkg::P_W;
  localparam int PRODW = PW + QW + 1;
  localparam int NSTEP = 7;
  localparam int RAD_W = 62;
  localparam int S_W   = RAD_W / 2;

  logic                    mvld_r  [NSTEP];
  logic signed [PRODW-1:0] prod_r  [NSTEP];
  logic [QW-1:0]           ma_r    [NSTEP];
  logic [SIDE_W-1:0]       mside_r [NSTEP];
  logic                    avld_r  [NSTEP];
  logic signed [PW-1:0]    p_r     [NSTEP];
  logic [QW-1:0]           aa_r    [NSTEP];
  logic [SIDE_W-1:0]       aside_r [NSTEP];

  // Each Horner step is a multiply stage followed by a truncate-and-add stage.
  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    logic                    v_in;
    logic signed [PW-1:0]    p_in;
    logic [QW-1:0]           a_in;
    logic [SIDE_W-1:0]       side_in;
    logic signed [PRODW-1:0] prod_nxt;
    logic signed [PRODW-1:0] padj;
    logic signed [PW-1:0]    p_nxt;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign p_in    = eavl_pkg::ACOS_COEF[0];
      assign a_in    = in_a;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = avld_r[k-1];
      assign p_in    = p_r[k-1];
      assign a_in    = aa_r[k-1];
      assign side_in = aside_r[k-1];
    end

    always_comb begin
      prod_nxt = PRODW'(p_in) * PRODW'($signed({1'b0, a_in}));
      // Truncation toward zero of a signed value divided by 2^24.
      padj     = prod_r[k] + (prod_r[k][PRODW-1] ? PRODW'(24'hFFFFFF) : PRODW'(0));
      p_nxt    = PW'(padj >>> 24) + eavl_pkg::ACOS_COEF[k+1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        mvld_r[k] <= 1'b0;
        avld_r[k] <= 1'b0;
      end else if (en) begin
        mvld_r[k] <= v_in;
        avld_r[k] <= mvld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        prod_r[k]  <= prod_nxt;
        ma_r[k]    <= a_in;
        mside_r[k] <= side_in;
        p_r[k]     <= p_nxt;
        aa_r[k]    <= ma_r[k];
        aside_r[k] <= mside_r[k];
      end
    end
  end

  logic [31:0]        pclamp;
  logic [QW-1:0]      one_minus_a;
  logic [RAD_W-1:0]   rad;
  logic               sq_valid;
  logic [S_W-1:0]     sq_root;
  logic [S_W+2:0]     sq_rem;
  logic [32+SIDE_W-1:0] sq_side;

  always_comb begin
    pclamp      = p_r[NSTEP-1][PW-1] ? 32'd0 : p_r[NSTEP-1][31:0];
    one_minus_a = eavl_pkg::ONE_Q24 - aa_r[NSTEP-1];
    rad         = {1'b0, one_minus_a, 36'd0};
  end

  eavl_isqrt #(
    .IN_W   (RAD_W),
    .SIDE_W (32 + SIDE_W)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (avld_r[NSTEP-1]),
    .in_rad    (rad),
    .in_side   ({pclamp, aside_r[NSTEP-1]}),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_rem   (sq_rem),
    .out_side  (sq_side)
  );

  logic              fvld_r;
  logic [63:0]       fprod_r;
  logic [SIDE_W-1:0] fside_r;
  logic              ovld_r;
  logic [19:0]       angle_r;
  logic [SIDE_W-1:0] oside_r;
  logic [63:0]       rounded;

  assign rounded = fprod_r + 64'h0000_0800_0000_0000;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fvld_r <= 1'b0;
      ovld_r <= 1'b0;
    end else if (en) begin
      fvld_r <= sq_valid;
      ovld_r <= fvld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fprod_r <= 64'(sq_root) * 64'(sq_side[32+SIDE_W-1 -: 32]);
      fside_r <= sq_side[SIDE_W-1:0];
      angle_r <= rounded[63:44];
      oside_r <= fside_r;
    end
  end

  assign out_valid = ovld_r;
  assign out_angle = angle_r;
  assign out_side  = oside_r;

endmodule

// ===== hw/rtl/elbow_angle_velocity_law.sv =====
// Top level of the elbow angle velocity law: configuration registers, the
// distance, clamp and error stages, and the output register.
// Depends on eavl_pkg, eavl_isqrt, eavl_div and eavl_acos.

// This block turns an end-effector position and a measured elbow angle into an
// elbow velocity command. For every input transaction it measures the distance
// from the configured shoulder point, clamps it to the arm's reach, takes the
// law-of-cosines elbow target minus pi, applies the dead zone to the angle
// error and scales it by the gain; exactly one output transaction follows each
// input transaction, in order. The block is a fully pipelined datapath that
// takes one input transaction in every clock cycle unless the output stalls;
// most of its registers lie in the bit-per-stage units: the 21-stage distance
// square root, the 25-stage cosine divider, the 14-stage arccosine polynomial
// and its 31-stage square root. The pipeline keeps moving while its last stage
// holds a bubble, so new input is taken even while a finished result waits on
// the output side. The user must write configuration through the cfg port only
// while no transaction is in flight; the block does not enforce this. Derived
// arm constants settle after a write via lua_r/lee_r, the products, den_r.
module elbow_angle_velocity_law (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata, low bit up: effector_x[19:0], effector_y[39:20],
  // effector_z[59:40], measured_angle[78:60], zero pad[79].
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [eavl_pkg::IN_TDATA_W-1:0] in_tdata,
  // out_tdata, low bit up: clamped_distance[18:0], target_angle[37:19],
  // angle_error[57:38], elbow_velocity[85:58], zero pad[87:86].
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [eavl_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [2:0]                      cfg_index,
  input  logic [eavl_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int DW = eavl_pkg::DEN_W;
  localparam int QW = eavl_pkg::Q_W;

  // ---------------------------------------------------------------------------
  // Configuration registers. Every write is taken at once; unused codes would
  // fall to the default arm.
  // ---------------------------------------------------------------------------
  logic signed [19:0] ref_x_r, ref_y_r, ref_z_r;
  logic [17:0]        upper_r, forearm_r, marker_r, deadzone_r;
  logic [7:0]         gain_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_x_r    <= '0;
      ref_y_r    <= '0;
      ref_z_r    <= '0;
      upper_r    <= 18'd19661;
      forearm_r  <= 18'd16384;
      marker_r   <= 18'd6554;
      gain_r     <= '0;
      deadzone_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (eavl_pkg::cfg_reg_t'(cfg_index))
        eavl_pkg::CFG_REF_X:    ref_x_r    <= cfg_data;
        eavl_pkg::CFG_REF_Y:    ref_y_r    <= cfg_data;
        eavl_pkg::CFG_REF_Z:    ref_z_r    <= cfg_data;
        eavl_pkg::CFG_UPPER:    upper_r    <= cfg_data[17:0];
        eavl_pkg::CFG_FOREARM:  forearm_r  <= cfg_data[17:0];
        eavl_pkg::CFG_MARKER:   marker_r   <= cfg_data[17:0];
        eavl_pkg::CFG_GAIN:     gain_r     <= cfg_data[7:0];
        eavl_pkg::CFG_DEADZONE: deadzone_r <= cfg_data[17:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Derived arm constants, recomputed every cycle from the registers. Lengths
  // are saturated so the denominator can never be zero.
  // ---------------------------------------------------------------------------
  logic [17:0] lua_c, lfa_c, lofs_c;
  logic [17:0] lua_r;
  logic [18:0] lee_r;
  logic [34:0] luasq_r;
  logic [36:0] leesq_r;
  logic [35:0] lprod_r;
  logic [18:0] hi_r, lo_r;
  logic [36:0] lsum_r;
  logic [DW-1:0] den_r;

  always_comb begin
    if (upper_r == 18'd0) begin
      lua_c = 18'd1;
    end else if (upper_r > eavl_pkg::LEN_MAX) begin
      lua_c = eavl_pkg::LEN_MAX;
    end else begin
      lua_c = upper_r;
    end
    if (forearm_r == 18'd0) begin
      lfa_c = 18'd1;
    end else if (forearm_r > eavl_pkg::LEN_MAX) begin
      lfa_c = eavl_pkg::LEN_MAX;
    end else begin
      lfa_c = forearm_r;
    end
    lofs_c = (marker_r > eavl_pkg::LEN_MAX) ? eavl_pkg::LEN_MAX : marker_r;
  end

  always_ff @(posedge clk) begin
    lua_r   <= lua_c;
    lee_r   <= {1'b0, lfa_c} + {1'b0, lofs_c};
    luasq_r <= 35'(lua_r * lua_r);
    leesq_r <= 37'(lee_r * lee_r);
    lprod_r <= 36'(lua_r * lee_r);
    hi_r    <= {1'b0, lua_r} + lee_r;
    lo_r    <= (lee_r > {1'b0, lua_r}) ? (lee_r - {1'b0, lua_r}) : ({1'b0, lua_r} - lee_r);
    lsum_r  <= {2'b00, luasq_r} + leesq_r;
    den_r   <= {lprod_r, 1'b0};
  end

  // ---------------------------------------------------------------------------
  // Pipeline advance. Every stage moves together; it stops only when the last
  // stage holds a result and the output register cannot take it.
  // ---------------------------------------------------------------------------
  logic en;
  logic v8_r;
  logic out_valid_r;

  assign en        = !v8_r || !out_valid_r || out_tready;
  assign in_tready = en;

  // Stage 0: coordinate differences.
  logic               v0_r;
  logic signed [20:0] dx_r, dy_r, dz_r;
  logic signed [18:0] meas0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r    <= 21'($signed(in_tdata[19:0])) - 21'(ref_x_r);
      dy_r    <= 21'($signed(in_tdata[39:20])) - 21'(ref_y_r);
      dz_r    <= 21'($signed(in_tdata[59:40])) - 21'(ref_z_r);
      meas0_r <= in_tdata[78:60];
    end
  end

  // Stage 1: squares. Stage 2: sum of squares.
  logic        v1_r, v2_r;
  logic [40:0] sqx_r, sqy_r, sqz_r;
  logic [41:0] sum_r;
  logic signed [18:0] meas1_r, meas2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r   <= 41'(dx_r * dx_r);
      sqy_r   <= 41'(dy_r * dy_r);
      sqz_r   <= 41'(dz_r * dz_r);
      meas1_r <= meas0_r;
      sum_r   <= 42'(sqx_r) + 42'(sqy_r) + 42'(sqz_r);
      meas2_r <= meas1_r;
    end
  end

  // Distance square root.
  logic        s1_valid;
  logic [20:0] s1_root;
  logic [23:0] s1_rem;
  logic [18:0] s1_meas;

  eavl_isqrt #(
    .IN_W   (42),
    .SIDE_W (19)
  ) u_dist_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v2_r),
    .in_rad    (sum_r),
    .in_side   (meas2_r),
    .out_valid (s1_valid),
    .out_root  (s1_root),
    .out_rem   (s1_rem),
    .out_side  (s1_meas)
  );

  // Stage 3: round to nearest and clamp to the reach. Stage 4: d squared.
  // Stage 5: numerator of the cosine as sign and magnitude.
  logic        v3_r, v4_r, v5_r;
  logic [21:0] d_round;
  logic [18:0] d_clamp;
  logic [18:0] d3_r, d4_r, d5_r;
  logic [18:0] meas3_r, meas4_r, meas5_r;
  logic [37:0] dsq_r;
  logic signed [38:0] num;
  logic [38:0] num_abs;
  logic        neg5_r;
  logic [DW-1:0] mag5_r;

  always_comb begin
    d_round = 22'(s1_root) + ((s1_rem > 24'(s1_root)) ? 22'd1 : 22'd0);
    if (d_round > 22'(hi_r)) begin
      d_clamp = hi_r;
    end else begin
      d_clamp = d_round[18:0];
    end
    if (d_clamp < lo_r) begin
      d_clamp = lo_r;
    end
    num     = $signed({2'b00, lsum_r}) - $signed({1'b0, dsq_r});
    num_abs = num[38] ? 39'(-num) : 39'(num);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d3_r    <= d_clamp;
      meas3_r <= s1_meas;
      dsq_r   <= 38'(d3_r * d3_r);
      d4_r    <= d3_r;
      meas4_r <= meas3_r;
      neg5_r  <= num[38];
      mag5_r  <= num_abs[DW-1:0];
      d5_r    <= d4_r;
      meas5_r <= meas4_r;
    end
  end

  // Cosine divider.
  logic          dv_valid;
  logic [QW-1:0] dv_quot;
  logic [38:0]   dv_side;

  eavl_div #(
    .SIDE_W (39)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .den       (den_r),
    .in_valid  (v5_r),
    .in_mag    (mag5_r),
    .in_side   ({neg5_r, d5_r, meas5_r}),
    .out_valid (dv_valid),
    .out_quot  (dv_quot),
    .out_side  (dv_side)
  );

  // Stage 6: saturate the cosine magnitude and settle its sign; a zero
  // quotient counts as a non-negative cosine.
  logic          v6_r;
  logic [QW-1:0] a6_r;
  logic          cneg6_r;
  logic [18:0]   d6_r, meas6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      a6_r    <= (dv_quot > eavl_pkg::ONE_Q24) ? eavl_pkg::ONE_Q24 : dv_quot;
      cneg6_r <= dv_side[38] && (dv_quot != '0);
      d6_r    <= dv_side[37:19];
      meas6_r <= dv_side[18:0];
    end
  end

  // Arccosine of the cosine magnitude.
  logic        ac_valid;
  logic [19:0] ac_angle;
  logic [38:0] ac_side;

  eavl_acos #(
    .SIDE_W (39)
  ) u_acos (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v6_r),
    .in_a      (a6_r),
    .in_side   ({cneg6_r, d6_r, meas6_r}),
    .out_valid (ac_valid),
    .out_angle (ac_angle),
    .out_side  (ac_side)
  );

  // Stage 7: elbow target, saturated to [-pi, 0].
  logic               v7_r;
  logic signed [21:0] t_raw;
  logic signed [18:0] t_sat;
  logic signed [18:0] target7_r, target8_r;
  logic [18:0]        d7_r, d8_r;
  logic signed [18:0] meas7_r;

  always_comb begin
    if (ac_side[38]) begin
      t_raw = -$signed({2'b00, ac_angle});
    end else begin
      t_raw = $signed({2'b00, ac_angle}) - 22'sd205887;
    end
    if (t_raw > 22'sd0) begin
      t_sat = 19'sd0;
    end else if (t_raw < -22'sd205887) begin
      t_sat = -19'sd205887;
    end else begin
      t_sat = t_raw[18:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      target7_r <= t_sat;
      d7_r      <= ac_side[37:19];
      meas7_r   <= ac_side[18:0];
    end
  end

  // Stage 8: dead-zoned angle error.
  logic signed [21:0] e_raw;
  logic [21:0]        e_mag;
  logic signed [21:0] e_dz;
  logic signed [21:0] err8_r;

  always_comb begin
    e_raw = 22'(target7_r) - 22'(meas7_r);
    e_mag = e_raw[21] ? 22'(-e_raw) : 22'(e_raw);
    if ((e_raw == 22'sd0) || (e_mag < 22'(deadzone_r))) begin
      e_dz = 22'sd0;
    end else if (e_raw[21]) begin
      e_dz = e_raw + $signed(22'(deadzone_r));
    end else begin
      e_dz = e_raw - $signed(22'(deadzone_r));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      err8_r    <= e_dz;
      target8_r <= target7_r;
      d8_r      <= d7_r;
    end
  end

  // Valid bits of the top-level stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_tvalid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= s1_valid;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= dv_valid;
      v7_r <= ac_valid;
      v8_r <= v7_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register. It takes the last stage's result when that stage is valid
  // and the pipeline advances; otherwise it empties once the result is taken.
  // ---------------------------------------------------------------------------
  logic signed [30:0]   vel;
  logic [eavl_pkg::OUT_TDATA_W-1:0] out_data_r;

  assign vel = 31'($signed({1'b0, gain_r})) * 31'(err8_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en && v8_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && v8_r) begin
      out_data_r <= {2'b00, vel[27:0], err8_r[19:0], target8_r, d8_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== hw/rtl/eavl_checker.sv =====
// Port-level checker of the elbow angle velocity law, bound to the top level.
// Depends on eavl_pkg and elbow_angle_velocity_law_defines.svh.
`include "elbow_angle_velocity_law_defines.svh"

module eavl_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [eavl_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [eavl_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             cfg_valid,
  input logic                             cfg_ready,
  input logic [2:0]                       cfg_index,
  input logic [eavl_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // A stalled result must hold until it is taken.
  `EAVL_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // The target angle stays within [-pi, 0].
  `EAVL_ASSERT_NOW(a_target_range, out_tvalid, ($signed(out_tdata[37:19]) <= 0) && ($signed(out_tdata[37:19]) >= -205887))

  // The clamped distance never exceeds the longest possible reach.
  `EAVL_ASSERT_NOW(a_dist_range, out_tvalid, out_tdata[18:0] <= 19'd393216)

  // No error means no motion, whatever the gain.
  `EAVL_ASSERT_NOW(a_zero_vel, out_tvalid && (out_tdata[57:38] == 20'd0), out_tdata[85:58] == 28'd0)

endmodule

bind elbow_angle_velocity_law eavl_checker u_eavl_checker (.*);
